// ===== design/urfl_pkg.sv =====
package urfl_pkg;

    // Item kinds carried in s_axis_tuser
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_LINE  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // Register addresses
    localparam logic [2:0] ADDR_DATA   = 3'd1;
    localparam logic [2:0] ADDR_STATUS = 3'd3;
    localparam logic [2:0] ADDR_MODE   = 3'd5;
    localparam logic [2:0] ADDR_CMD    = 3'd7;

    // Sync write pointer codes
    localparam logic [1:0] SYNC_ONE = 2'd0;
    localparam logic [1:0] SYNC_TWO = 2'd1;
    localparam logic [1:0] SYNC_DLE = 2'd2;

    // Status bits
    localparam logic [5:0] ST_TXRDY = 6'h01;
    localparam logic [5:0] ST_RXRDY = 6'h02;
    localparam logic [5:0] ST_PERR  = 6'h08;
    localparam logic [5:0] ST_OERR  = 6'h10;
    localparam logic [5:0] ST_FERR  = 6'h20;
    localparam logic [5:0] ST_ERR   = ST_PERR | ST_OERR | ST_FERR;
    localparam logic [5:0] ST_IRQ   = ST_RXRDY | ST_TXRDY;

    // Command bits
    localparam logic [7:0] CM_TXEN  = 8'h01;
    localparam logic [7:0] CM_DTR   = 8'h02;
    localparam logic [7:0] CM_RXEN  = 8'h04;
    localparam logic [7:0] CM_BREAK = 8'h08;
    localparam logic [7:0] CM_RESET = 8'h10;
    localparam logic [7:0] CM_LOOP  = 8'h80;
    localparam logic [7:0] CM_MODE  = 8'hC0;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] reg_addr;
        logic [7:0] data_in;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_level;
    } result_t;

endpackage

// ===== design/uart_register_file_loopback_top.sv =====
// UART register file with loopback. Each input item is a bus read, a bus
// write or a byte from the line (selected by s_axis_tuser) and gives exactly
// one result item with the read data, the byte sent to the line if any, and
// the interrupt level after the item. One item is accepted every cycle unless
// the result side stalls; an item passes through the input register, then the
// result register, and the register file update sits in the single stage
// between them. Backpressure on the result side stalls both stages.
module uart_register_file_loopback_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [2:0] reg_addr, [10:3] data_in, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] read_data, [15:8] tx_byte, [16] irq_level
    output logic        m_axis_tuser    // [0] tx_valid
);

    logic              in_valid_reg;
    urfl_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    urfl_pkg::result_t out_result_reg;
    urfl_pkg::result_t result;
    logic              advance;
    logic              fire;

    // Result register can take a new item when empty or being drained
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.kind     <= urfl_pkg::kind_t'(s_axis_tuser);
            in_item_reg.reg_addr <= s_axis_tdata[2:0];
            in_item_reg.data_in  <= s_axis_tdata[10:3];
        end
        if (fire)
            out_result_reg <= result;
    end

    urfl_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_result_reg.irq_level, out_result_reg.tx_byte,
                            out_result_reg.read_data};
    assign m_axis_tuser  = out_result_reg.tx_valid;

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("stalled item lost from input register");

    a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed item did not reach result register");

    a_no_tx_byte_without_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_result_reg.tx_valid |-> out_result_reg.tx_byte == 8'h00)
        else $error("tx byte nonzero without a send");

endmodule

// ===== design/urfl_core.sv =====
module urfl_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  urfl_pkg::item_t   item,
    output urfl_pkg::result_t result
);

    logic [7:0] rx_holding_reg, rx_holding_next;
    logic [7:0] tx_holding_reg, tx_holding_next;
    logic [5:0] status_reg, status_next;
    logic [7:0] mode_one_reg, mode_one_next;
    logic [7:0] mode_two_reg, mode_two_next;
    logic [7:0] sync_one_reg, sync_one_next;
    logic [7:0] sync_two_reg, sync_two_next;
    logic [7:0] dle_char_reg, dle_char_next;
    logic [7:0] command_reg, command_next;
    logic       mode_ptr_reg, mode_ptr_next;
    logic [1:0] sync_ptr_reg, sync_ptr_next;
    logic [7:0] rd;
    logic       sent;

    always_comb
    begin
        rx_holding_next = rx_holding_reg;
        tx_holding_next = tx_holding_reg;
        status_next     = status_reg;
        mode_one_next   = mode_one_reg;
        mode_two_next   = mode_two_reg;
        sync_one_next   = sync_one_reg;
        sync_two_next   = sync_two_reg;
        dle_char_next   = dle_char_reg;
        command_next    = command_reg;
        mode_ptr_next   = mode_ptr_reg;
        sync_ptr_next   = sync_ptr_reg;
        rd              = 8'h00;
        sent            = 1'b0;
        case (item.kind)
            urfl_pkg::KIND_READ:
            begin
                case (item.reg_addr)
                    urfl_pkg::ADDR_DATA:
                    begin
                        status_next = status_reg & ~urfl_pkg::ST_RXRDY;
                        rd          = rx_holding_reg;
                    end
                    urfl_pkg::ADDR_STATUS: rd = {2'b00, status_reg};
                    urfl_pkg::ADDR_MODE:   rd = mode_ptr_reg ? mode_two_reg : mode_one_reg;
                    urfl_pkg::ADDR_CMD:    rd = command_reg;
                    default:               rd = 8'h00;
                endcase
            end
            urfl_pkg::KIND_WRITE:
            begin
                case (item.reg_addr)
                    urfl_pkg::ADDR_DATA:
                    begin
                        tx_holding_next = item.data_in;
                        if ((command_reg & urfl_pkg::CM_TXEN) != 8'h00)
                        begin
                            // Loopback mode feeds the byte straight back to receive
                            if ((command_reg & urfl_pkg::CM_MODE) == urfl_pkg::CM_LOOP)
                            begin
                                status_next     = status_reg | urfl_pkg::ST_IRQ;
                                rx_holding_next = item.data_in;
                            end
                            else
                            begin
                                status_next = status_reg | urfl_pkg::ST_TXRDY;
                                sent        = 1'b1;
                            end
                        end
                    end
                    urfl_pkg::ADDR_STATUS:
                    begin
                        case (sync_ptr_reg)
                            urfl_pkg::SYNC_ONE:
                            begin
                                sync_one_next = item.data_in;
                                sync_ptr_next = urfl_pkg::SYNC_TWO;
                            end
                            urfl_pkg::SYNC_TWO:
                            begin
                                sync_two_next = item.data_in;
                                sync_ptr_next = urfl_pkg::SYNC_DLE;
                            end
                            default:
                            begin
                                dle_char_next = item.data_in;
                                sync_ptr_next = urfl_pkg::SYNC_DLE;
                            end
                        endcase
                    end
                    urfl_pkg::ADDR_MODE:
                    begin
                        if (mode_ptr_reg)
                            mode_two_next = item.data_in;
                        else
                            mode_one_next = item.data_in;
                        mode_ptr_next = 1'b1;
                    end
                    urfl_pkg::ADDR_CMD:
                    begin
                        command_next = item.data_in;
                        status_next  = status_reg;
                        if ((item.data_in & urfl_pkg::CM_RESET) != 8'h00)
                            status_next = status_next & ~urfl_pkg::ST_ERR;
                        if ((item.data_in & urfl_pkg::CM_TXEN) != 8'h00)
                            status_next = status_next | urfl_pkg::ST_TXRDY;
                        else
                            status_next = status_next & ~urfl_pkg::ST_TXRDY;
                    end
                    default:
                    begin
                        sent = 1'b0;
                    end
                endcase
            end
            urfl_pkg::KIND_LINE:
            begin
                rx_holding_next = item.data_in;
                if ((command_reg & urfl_pkg::CM_RXEN) != 8'h00)
                    status_next = status_reg | urfl_pkg::ST_RXRDY;
            end
            default:
            begin
                rd = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_holding_reg <= 8'h00;
            tx_holding_reg <= 8'h00;
            status_reg     <= 6'h00;
            mode_one_reg   <= 8'h00;
            mode_two_reg   <= 8'h00;
            sync_one_reg   <= 8'h00;
            sync_two_reg   <= 8'h00;
            dle_char_reg   <= 8'h00;
            command_reg    <= 8'h00;
            mode_ptr_reg   <= 1'b0;
            sync_ptr_reg   <= urfl_pkg::SYNC_ONE;
        end
        else if (fire)
        begin
            rx_holding_reg <= rx_holding_next;
            tx_holding_reg <= tx_holding_next;
            status_reg     <= status_next;
            mode_one_reg   <= mode_one_next;
            mode_two_reg   <= mode_two_next;
            sync_one_reg   <= sync_one_next;
            sync_two_reg   <= sync_two_next;
            dle_char_reg   <= dle_char_next;
            command_reg    <= command_next;
            mode_ptr_reg   <= mode_ptr_next;
            sync_ptr_reg   <= sync_ptr_next;
        end
    end

    assign result.read_data = rd;
    assign result.tx_valid  = sent;
    assign result.tx_byte   = sent ? tx_holding_next : 8'h00;
    assign result.irq_level = (status_next & urfl_pkg::ST_IRQ) != 6'h00;

    a_tx_only_on_data_write: assert property (@(posedge clk) disable iff (!rst_n)
        fire && sent |-> item.kind == urfl_pkg::KIND_WRITE && item.reg_addr == urfl_pkg::ADDR_DATA)
        else $error("line byte sent by an item that is not a data write");

    a_errors_never_set: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg & urfl_pkg::ST_ERR) == 6'h00)
        else $error("error status bit set");

    a_sync_ptr_legal: assert property (@(posedge clk) disable iff (!rst_n)
        sync_ptr_reg == urfl_pkg::SYNC_ONE || sync_ptr_reg == urfl_pkg::SYNC_TWO ||
        sync_ptr_reg == urfl_pkg::SYNC_DLE)
        else $error("sync pointer out of range");

    a_mode_ptr_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        mode_ptr_reg |=> mode_ptr_reg)
        else $error("mode pointer returned to mode one");

endmodule

// ===== tb/sv/uart_regfile_checker.sv =====
`timescale 1ns / 1ps

module uart_regfile_checker
    import urfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [2:0] reg_addr, [10:3] data_in, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [7:0] read_data, [15:8] tx_byte, [16] irq_level
    input  logic        m_axis_tuser,   // [0] tx_valid
    output int          fail_count,
    output int          pending
);

    // Shadow copy of the register file
    logic [7:0] rx_hold;
    logic [7:0] tx_hold;
    logic [5:0] status;
    logic [7:0] mode1;
    logic [7:0] mode2;
    logic [7:0] sync1;
    logic [7:0] sync2;
    logic [7:0] dle;
    logic [7:0] command;
    logic       mode_sel;
    logic [1:0] sync_sel;

    result_t uart_resp_q[$];

    function automatic result_t uart_apply(kind_t kind, logic [2:0] addr, logic [7:0] d);
        result_t r;
        r = '0;
        case (kind)
            KIND_READ:
                case (addr)
                    ADDR_DATA:
                    begin
                        status &= ~ST_RXRDY;
                        r.read_data = rx_hold;
                    end
                    ADDR_STATUS: r.read_data = {2'b00, status};
                    ADDR_MODE:   r.read_data = mode_sel ? mode2 : mode1;
                    ADDR_CMD:    r.read_data = command;
                    default:     r.read_data = 8'h00;
                endcase
            KIND_WRITE:
                case (addr)
                    ADDR_DATA:
                    begin
                        tx_hold = d;
                        if ((command & CM_TXEN) != 0) begin
                            if ((command & CM_MODE) == CM_LOOP) begin
                                // loopback: byte lands in the receive register
                                status |= ST_RXRDY | ST_TXRDY;
                                rx_hold = d;
                            end else begin
                                status |= ST_TXRDY;
                                r.tx_valid = 1'b1;
                                r.tx_byte  = d;
                            end
                        end
                    end
                    ADDR_STATUS:
                    begin
                        // sync1, sync2, then DLE for good
                        if (sync_sel == SYNC_ONE) begin
                            sync1 = d;
                            sync_sel = SYNC_TWO;
                        end else if (sync_sel == SYNC_TWO) begin
                            sync2 = d;
                            sync_sel = SYNC_DLE;
                        end else begin
                            dle = d;
                            sync_sel = SYNC_DLE;
                        end
                    end
                    ADDR_MODE:
                    begin
                        if (mode_sel)
                            mode2 = d;
                        else
                            mode1 = d;
                        mode_sel = 1'b1;
                    end
                    ADDR_CMD:
                    begin
                        command = d;
                        if ((d & CM_RESET) != 0)
                            status &= ~ST_ERR;
                        if ((d & CM_TXEN) != 0)
                            status |= ST_TXRDY;
                        else
                            status &= ~ST_TXRDY;
                    end
                    default: ;
                endcase
            KIND_LINE:
            begin
                rx_hold = d;
                if ((command & CM_RXEN) != 0)
                    status |= ST_RXRDY;
            end
            default: ;
        endcase
        r.irq_level = |(status & ST_IRQ);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            rx_hold  = '0;
            tx_hold  = '0;
            status   = '0;
            mode1    = '0;
            mode2    = '0;
            sync1    = '0;
            sync2    = '0;
            dle      = '0;
            command  = '0;
            mode_sel = 1'b0;
            sync_sel = SYNC_ONE;
            uart_resp_q.delete();
            fail_count = 0;
        end else begin
            // compare before pushing, so a new item never answers an early result
            if (m_axis_tvalid && m_axis_tready) begin
                if (uart_resp_q.size() == 0) begin
                    $error("unexpected result item: tdata %h tuser %b", m_axis_tdata,
                           m_axis_tuser);
                    fail_count++;
                end else begin
                    want = uart_resp_q.pop_front();
                    if (m_axis_tdata[7:0] !== want.read_data) begin
                        $error("read_data: expected %h, got %h", want.read_data,
                               m_axis_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_axis_tuser !== want.tx_valid) begin
                        $error("tx_valid: expected %b, got %b", want.tx_valid, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[15:8] !== want.tx_byte) begin
                        $error("tx_byte: expected %h, got %h", want.tx_byte,
                               m_axis_tdata[15:8]);
                        fail_count++;
                    end
                    if (m_axis_tdata[16] !== want.irq_level) begin
                        $error("irq_level: expected %b, got %b", want.irq_level,
                               m_axis_tdata[16]);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                uart_resp_q.push_back(uart_apply(kind_t'(s_axis_tuser), s_axis_tdata[2:0],
                                                 s_axis_tdata[10:3]));
        end
        pending = uart_resp_q.size();
    end

endmodule

// ===== tb/sv/tb_uart_register_file_loopback_top.sv =====
`timescale 1ns / 1ps

module tb_uart_register_file_loopback_top;

    import urfl_pkg::*;

    localparam int ITEMS_PER_PHASE = 290;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [2:0] reg_addr, [10:3] data_in, rest zero
    logic [1:0]  s_axis_tuser = KIND_READ;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [7:0] read_data, [15:8] tx_byte, [16] irq_level
    logic        m_axis_tuser;         // [0] tx_valid

    int fail_count;
    int pending;
    int src_idle_pct = 10;
    int sink_idle_pct = 76;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    uart_register_file_loopback_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    uart_regfile_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_uart_register_file_loopback_top failed");
            $finish;
        end
    end

    task automatic send_item(input kind_t kind, input logic [2:0] addr, input logic [7:0] d);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'b0, d, addr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    initial begin
        kind_t      kind;
        logic [2:0] addr;
        logic [7:0] d;
        int         pick;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values, unused address, mode pointer
        send_item(KIND_READ, 3'd0, 8'h00);
        send_item(KIND_READ, ADDR_STATUS, 8'h00);
        send_item(KIND_READ, ADDR_MODE, 8'h00);
        send_item(KIND_WRITE, ADDR_MODE, 8'hFF);
        send_item(KIND_READ, ADDR_MODE, 8'h00);
        send_item(KIND_WRITE, ADDR_MODE, 8'hA5);
        send_item(KIND_READ, ADDR_MODE, 8'hFF);
        // Sync sequence ends on DLE and stays there
        send_item(KIND_WRITE, ADDR_STATUS, 8'h16);
        send_item(KIND_WRITE, ADDR_STATUS, 8'h00);
        send_item(KIND_WRITE, ADDR_STATUS, 8'hFF);
        send_item(KIND_WRITE, ADDR_STATUS, 8'h55);
        // Transmit and receive both disabled
        send_item(KIND_WRITE, ADDR_DATA, 8'h3C);
        send_item(KIND_LINE, 3'd7, 8'hFF);
        send_item(KIND_READ, ADDR_STATUS, 8'h00);
        // Transmit, DTR, receive, break and reset bits, normal mode: byte goes to the line
        send_item(KIND_WRITE, ADDR_CMD, CM_TXEN | CM_DTR | CM_RXEN | CM_BREAK | CM_RESET);
        send_item(KIND_WRITE, ADDR_DATA, 8'hFF);
        send_item(KIND_LINE, 3'd0, 8'h00);
        send_item(KIND_READ, ADDR_STATUS, 8'h00);
        send_item(KIND_READ, ADDR_DATA, 8'h00);
        // Loopback mode
        send_item(KIND_WRITE, ADDR_CMD, CM_LOOP | CM_RXEN | CM_TXEN);
        send_item(KIND_WRITE, ADDR_DATA, 8'h81);
        send_item(KIND_READ, ADDR_DATA, 8'h00);
        // Ignored kind, unused write, transmit off again
        send_item(KIND_NONE, 3'd6, 8'hFF);
        send_item(KIND_WRITE, 3'd6, 8'hFF);
        send_item(KIND_WRITE, ADDR_CMD, 8'h00);
        send_item(KIND_READ, ADDR_CMD, 8'h00);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 10;
                    sink_idle_pct = 76;
                end
                1:
                begin
                    src_idle_pct  = 76;
                    sink_idle_pct = 10;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // hold the result side off while items keep coming
                if (phase == 2 && i == 60)
                    hold_req++;
                pick = $urandom_range(99);
                if (pick < 4)
                    kind = KIND_NONE;
                else if (pick < 40)
                    kind = KIND_READ;
                else if (pick < 80)
                    kind = KIND_WRITE;
                else
                    kind = KIND_LINE;
                if ($urandom_range(9) == 0)
                    addr = 3'($urandom_range(7));
                else
                    addr = 3'($urandom_range(3) * 2 + 1);
                d = 8'($urandom_range(255));
                // steer some command writes into loopback with transmit on
                if (kind == KIND_WRITE && addr == ADDR_CMD && $urandom_range(2) == 0)
                    d = (d & ~CM_MODE) | CM_LOOP | CM_TXEN;
                send_item(kind, addr, d);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb_uart_register_file_loopback_top passed");
        else
            $display("tb_uart_register_file_loopback_top failed");
        $finish;
    end

endmodule
